[src/olr_pkg.sv]
// olr_pkg: shared types and codes for the octant line rasterizer
// no dependencies; imported by the setup stage, the top level and the checker
`default_nettype none

package olr_pkg;

  // function code of an input beat
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // octant of a line, numbered counterclockwise from the east-north-east one
  typedef enum logic [2:0] {
    OCT_ENE = 3'd0,
    OCT_NNE = 3'd1,
    OCT_NNW = 3'd2,
    OCT_WNW = 3'd3,
    OCT_WSW = 3'd4,
    OCT_SSW = 3'd5,
    OCT_SSE = 3'd6,
    OCT_ESE = 3'd7
  } octant_t;

endpackage

`default_nettype wire

[src/olr_line_if.sv]
// olr_line_if: valid/ready channel that carries line loads and step ticks
// standalone; used by octant_line_rasterizer
`default_nettype none

interface olr_line_if #(parameter int COORD_BITS = 12);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, func, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, func, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

[src/olr_pixel_if.sv]
// olr_pixel_if: valid/ready channel that carries rasterized pixels
// standalone; used by octant_line_rasterizer
`default_nettype none

interface olr_pixel_if #(parameter int COORD_BITS = 12);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

`default_nettype wire

[src/olr_setup.sv]
// olr_setup: line setup, picks the octant and folds the endpoints into the first octant
// depends on olr_pkg
`default_nettype none

module olr_setup import olr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output octant_t                      octant,
  output logic signed [COORD_BITS:0]   walk_major,
  output logic signed [COORD_BITS:0]   walk_minor,
  output logic signed [COORD_BITS:0]   major_end,
  output logic signed [COORD_BITS+2:0] decision,
  output logic        [COORD_BITS:0]   step_east,
  output logic signed [COORD_BITS+1:0] step_northeast,
  output logic                         active
);

  localparam int MW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 3;

  logic signed [MW-1:0]         sx, sy, ex, ey;
  logic signed [MW-1:0]         dx, dy;
  logic        [MW-1:0]         ax, ay;
  logic                         x_major;
  logic        [COORD_BITS-1:0] ddx, ddy;

  // deltas and their magnitudes, one bit wider than a coordinate
  assign sx = {start_x[COORD_BITS-1], start_x};
  assign sy = {start_y[COORD_BITS-1], start_y};
  assign ex = {end_x[COORD_BITS-1], end_x};
  assign ey = {end_y[COORD_BITS-1], end_y};
  assign dx = ex - sx;
  assign dy = ey - sy;
  assign ax = dx[MW-1] ? $unsigned(-dx) : $unsigned(dx);
  assign ay = dy[MW-1] ? $unsigned(-dy) : $unsigned(dy);
  assign x_major = (ax >= ay);

  // octant from the delta signs, ties go to the x-major octant
  always_comb begin
    unique case ({dx[MW-1], dy[MW-1]})
      2'b00:   octant = x_major ? OCT_ENE : OCT_NNE;
      2'b10:   octant = x_major ? OCT_WNW : OCT_NNW;
      2'b11:   octant = x_major ? OCT_WSW : OCT_SSW;
      default: octant = x_major ? OCT_ESE : OCT_SSE;
    endcase
  end

  // start point mirrored into the first octant
  always_comb begin
    unique case (octant)
      OCT_ENE: begin walk_major = sx;  walk_minor = sy;  end
      OCT_NNE: begin walk_major = sy;  walk_minor = sx;  end
      OCT_NNW: begin walk_major = sy;  walk_minor = -sx; end
      OCT_WNW: begin walk_major = -sx; walk_minor = sy;  end
      OCT_WSW: begin walk_major = -sx; walk_minor = -sy; end
      OCT_SSW: begin walk_major = -sy; walk_minor = -sx; end
      OCT_SSE: begin walk_major = -sy; walk_minor = sx;  end
      default: begin walk_major = sx;  walk_minor = -sy; end
    endcase
  end

  // folded deltas: major is the larger magnitude
  assign ddx = x_major ? ax[COORD_BITS-1:0] : ay[COORD_BITS-1:0];
  assign ddy = x_major ? ay[COORD_BITS-1:0] : ax[COORD_BITS-1:0];

  // end of the walk and midpoint decision terms
  assign major_end      = walk_major + $signed({1'b0, ddx});
  assign decision       = $signed({2'b00, ddy, 1'b0}) - $signed({{(DW-COORD_BITS){1'b0}}, ddx});
  assign step_east      = {ddy, 1'b0};
  assign step_northeast = $signed({1'b0, ddy, 1'b0}) - $signed({1'b0, ddx, 1'b0});
  assign active         = (ddx != '0);

endmodule

`default_nettype wire

[src/octant_line_rasterizer.sv]
// Octant line rasterizer: takes one beat per clock while ready is high. A load beat
// (func = 0) latches a line's endpoints; each step tick (func = 1) returns the next pixel
// of the active line, the start point excluded and the end point flagged with last_pixel.
// A tick passes through the input register, then the setup/step logic writes its pixel
// into the output register. Throughput is one pixel per clock while the output is not
// stalled, set by the decision update on the walk registers; ready drops only while the
// output register holds a pixel that is not being taken. A load replaces any active line,
// a zero-length line gives no pixels, and ticks with no active line give nothing.
// depends on olr_pkg, olr_line_if, olr_pixel_if, olr_setup
`default_nettype none

module octant_line_rasterizer import olr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  olr_line_if.sink     in_line,
  olr_pixel_if.source  out_pixel
);

  localparam int MW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 3;
  localparam int NW = COORD_BITS + 2;
  localparam logic signed [MW-1:0] ONE_M = MW'(1);

  // input register
  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_func_r;
  logic signed [COORD_BITS-1:0] s1_sx_r, s1_sy_r, s1_ex_r, s1_ey_r;

  // walk state
  logic signed [MW-1:0]         major_r, minor_r, major_end_r;
  logic signed [DW-1:0]         decision_r;
  logic        [MW-1:0]         step_east_r;
  logic signed [NW-1:0]         step_ne_r;
  octant_t                      octant_r;
  logic                         active_r, active_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                         out_last_r;

  // setup results
  octant_t                      ld_octant;
  logic signed [MW-1:0]         ld_major, ld_minor, ld_major_end;
  logic signed [DW-1:0]         ld_decision;
  logic        [MW-1:0]         ld_step_east;
  logic signed [NW-1:0]         ld_step_ne;
  logic                         ld_active;

  // step results
  logic                         turn_ne;
  logic signed [DW-1:0]         decision_step;
  logic signed [MW-1:0]         major_step, minor_step;
  logic                         last_step;
  logic signed [MW-1:0]         px, py;

  // handshake
  logic                         in_acc, out_free, s1_load, s1_emit, s1_go;

  olr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .start_x        (s1_sx_r),
    .start_y        (s1_sy_r),
    .end_x          (s1_ex_r),
    .end_y          (s1_ey_r),
    .octant         (ld_octant),
    .walk_major     (ld_major),
    .walk_minor     (ld_minor),
    .major_end      (ld_major_end),
    .decision       (ld_decision),
    .step_east      (ld_step_east),
    .step_northeast (ld_step_ne),
    .active         (ld_active)
  );

  // flow control: the held beat moves unless it needs the output register and that is full
  assign out_free  = !out_valid_r || out_pixel.ready;
  assign s1_load   = (s1_func_r == FUNC_LOAD);
  assign s1_emit   = (s1_func_r == FUNC_STEP) && active_r;
  assign s1_go     = s1_valid_r && (!s1_emit || out_free);
  assign in_line.ready = !s1_valid_r || s1_go;
  assign in_acc    = in_line.valid && in_line.ready;

  // one midpoint step
  assign turn_ne       = !decision_r[DW-1];
  assign decision_step = turn_ne ? decision_r + DW'(step_ne_r)
                                 : decision_r + $signed({2'b00, step_east_r});
  assign major_step    = major_r + ONE_M;
  assign minor_step    = turn_ne ? minor_r + ONE_M : minor_r;
  assign last_step     = (major_step >= major_end_r);

  // unfold the new point back into the line's octant
  always_comb begin
    unique case (octant_r)
      OCT_ENE: begin px = major_step;  py = minor_step;  end
      OCT_NNE: begin px = minor_step;  py = major_step;  end
      OCT_NNW: begin px = -minor_step; py = major_step;  end
      OCT_WNW: begin px = -major_step; py = minor_step;  end
      OCT_WSW: begin px = -major_step; py = -minor_step; end
      OCT_SSW: begin px = -minor_step; py = -major_step; end
      OCT_SSE: begin px = minor_step;  py = -major_step; end
      default: begin px = major_step;  py = -minor_step; end
    endcase
  end

  // next control state
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_go && s1_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pixel.ready) begin
      out_valid_nxt = 1'b0;
    end

    active_nxt = active_r;
    if (s1_go && s1_load) begin
      active_nxt = ld_active;
    end else if (s1_go && s1_emit) begin
      active_nxt = !last_step;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_line.func;
      s1_sx_r   <= in_line.start_x;
      s1_sy_r   <= in_line.start_y;
      s1_ex_r   <= in_line.end_x;
      s1_ey_r   <= in_line.end_y;
    end
  end

  // walk state update on load or on a pixel step
  always_ff @(posedge clk) begin
    if (s1_go && s1_load) begin
      octant_r    <= ld_octant;
      major_r     <= ld_major;
      minor_r     <= ld_minor;
      major_end_r <= ld_major_end;
      decision_r  <= ld_decision;
      step_east_r <= ld_step_east;
      step_ne_r   <= ld_step_ne;
    end else if (s1_go && s1_emit) begin
      major_r    <= major_step;
      minor_r    <= minor_step;
      decision_r <= decision_step;
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_x_r    <= px[COORD_BITS-1:0];
      out_y_r    <= py[COORD_BITS-1:0];
      out_last_r <= last_step;
    end
  end

  assign out_pixel.valid      = out_valid_r;
  assign out_pixel.pixel_x    = out_x_r;
  assign out_pixel.pixel_y    = out_y_r;
  assign out_pixel.last_pixel = out_last_r;

endmodule

`default_nettype wire

[src/olr_checker.sv]
// olr_checker: port-level assertions for the octant line rasterizer, bound to the top level
// depends on olr_pkg and octant_line_rasterizer
`default_nettype none

module olr_checker import olr_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_func,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // a stalled pixel beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last))
    else $error("pixel beat dropped or changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // the input side never waits on a free output
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with room at the output");

  // a fresh pixel follows an accepted step tick
  a_pixel_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n) && $past(in_valid && in_ready && in_func == FUNC_STEP, 2))
    else $error("pixel without a step tick");

endmodule

bind octant_line_rasterizer olr_checker u_olr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_line.valid),
  .in_ready  (in_line.ready),
  .in_func   (in_line.func),
  .out_valid (out_pixel.valid),
  .out_ready (out_pixel.ready),
  .out_last  (out_pixel.last_pixel)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// tb_top: self-checking bench for octant_line_rasterizer, with a pixel ledger that predicts
// the midpoint walk of every loaded line and checks each pixel beat against it
// depends on olr_pkg, olr_line_if, olr_pixel_if and the rasterizer top level
`timescale 1ns / 100ps

import olr_pkg::*;

// predicts the pixels of the current line and checks the ones the block sends back
class pixel_ledger #(parameter int CW = 12);
  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } pixel_t;

  // walk state, octant-0 coordinates are one bit wider than a field
  logic signed [CW:0]   walk_major;
  logic signed [CW:0]   walk_minor;
  logic signed [CW:0]   major_end;
  logic signed [CW+3:0] decision;
  logic [CW+1:0]        step_east;
  logic signed [CW+2:0] step_northeast;
  octant_t              octant;
  bit                   active;

  pixel_t pixels_due[$];
  int     mismatches;

  function new();
    walk_major     = '0;
    walk_minor     = '0;
    major_end      = '0;
    decision       = '0;
    step_east      = '0;
    step_northeast = '0;
    octant         = OCT_ENE;
    active         = 1'b0;
    mismatches     = 0;
  endfunction

  task report_mismatch(input string what);
    $display("tb_top: mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function int pending();
    return pixels_due.size();
  endfunction

  function octant_t classify(input int dx, input int dy);
    int ax;
    int ay;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (dx >= 0 && dy >= 0) return (ax >= ay) ? OCT_ENE : OCT_NNE;
    if (dx < 0 && dy >= 0) return (ax >= ay) ? OCT_WNW : OCT_NNW;
    if (dx < 0 && dy < 0) return (ax >= ay) ? OCT_WSW : OCT_SSW;
    return (ax >= ay) ? OCT_ESE : OCT_SSE;
  endfunction

  // mirror/swap a point into octant 0
  function void fold(input octant_t o, input int x, input int y, output int a, output int b);
    case (o)
      OCT_ENE: begin a = x;  b = y;  end
      OCT_NNE: begin a = y;  b = x;  end
      OCT_NNW: begin a = y;  b = -x; end
      OCT_WNW: begin a = -x; b = y;  end
      OCT_WSW: begin a = -x; b = -y; end
      OCT_SSW: begin a = -y; b = -x; end
      OCT_SSE: begin a = -y; b = x;  end
      default: begin a = x;  b = -y; end
    endcase
  endfunction

  // map an octant-0 point back to the line's own octant
  function void unfold(input octant_t o, input int a, input int b, output int x, output int y);
    case (o)
      OCT_ENE: begin x = a;  y = b;  end
      OCT_NNE: begin x = b;  y = a;  end
      OCT_NNW: begin x = -b; y = a;  end
      OCT_WNW: begin x = -a; y = b;  end
      OCT_WSW: begin x = -a; y = -b; end
      OCT_SSW: begin x = -b; y = -a; end
      OCT_SSE: begin x = b;  y = -a; end
      default: begin x = a;  y = -b; end
    endcase
  endfunction

  // note one accepted input beat; a step on an active line queues one pixel
  function void take_beat(input logic func, input logic signed [CW-1:0] sx,
                          input logic signed [CW-1:0] sy, input logic signed [CW-1:0] ex,
                          input logic signed [CW-1:0] ey);
    int     x0, y0, x1, y1;
    int     a0, b0, a1, b1;
    int     ddx, ddy, px, py;
    pixel_t pix;
    x0 = sx;
    y0 = sy;
    x1 = ex;
    y1 = ey;
    if (func == FUNC_LOAD) begin
      octant = classify(x1 - x0, y1 - y0);
      fold(octant, x0, y0, a0, b0);
      fold(octant, x1, y1, a1, b1);
      ddx            = a1 - a0;
      ddy            = b1 - b0;
      walk_major     = a0;
      walk_minor     = b0;
      major_end      = a1;
      decision       = 2 * ddy - ddx;
      step_east      = 2 * ddy;
      step_northeast = 2 * (ddy - ddx);
      active         = (a0 < a1);
    end else if (active) begin
      // midpoint step: east or north-east
      if (decision < 0) begin
        decision = decision + $signed({2'b00, step_east});
      end else begin
        decision   = decision + step_northeast;
        walk_minor = walk_minor + 1;
      end
      walk_major = walk_major + 1;
      pix.last   = (walk_major >= major_end);
      if (pix.last) active = 1'b0;
      unfold(octant, walk_major, walk_minor, px, py);
      pix.x = px[CW-1:0];
      pix.y = py[CW-1:0];
      pixels_due.push_back(pix);
    end
  endfunction

  // compare one pixel beat with the oldest expected pixel
  task match_pixel(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                   input logic last);
    pixel_t want;
    if (pixels_due.size() == 0) begin
      report_mismatch($sformatf("pixel (%0d,%0d) last=%0b with none expected", x, y, last));
    end else begin
      want = pixels_due.pop_front();
      if (x !== want.x)
        report_mismatch($sformatf("pixel_x %0d, expected %0d", x, want.x));
      if (y !== want.y)
        report_mismatch($sformatf("pixel_y %0d, expected %0d", y, want.y));
      if (last !== want.last)
        report_mismatch($sformatf("last_pixel %0b, expected %0b", last, want.last));
    end
  endtask

  task flag_leftover();
    if (pixels_due.size() != 0)
      report_mismatch($sformatf("%0d expected pixels never arrived", pixels_due.size()));
  endtask
endclass

module tb_top;
  localparam int COORD_BITS = 12;
  localparam int CMIN       = -(1 << (COORD_BITS - 1));
  localparam int CMAX       = (1 << (COORD_BITS - 1)) - 1;
  localparam int HOLD_LEN   = 400;

  logic clk = 1'b0;
  logic rst_n;

  olr_line_if  #(.COORD_BITS(COORD_BITS)) line_if ();
  olr_pixel_if #(.COORD_BITS(COORD_BITS)) pix_if ();

  octant_line_rasterizer #(.COORD_BITS(COORD_BITS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_line  (line_if),
    .out_pixel(pix_if)
  );

  pixel_ledger #(COORD_BITS) ledger;

  bit send_idle;
  bit recv_idle;
  bit pix_taken;
  int hold_req;
  int beats_sent;

  always #5 clk = ~clk;

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
        ledger.match_pixel(pix_if.pixel_x, pix_if.pixel_y, pix_if.last_pixel);
        pix_taken = 1'b1;
      end
      if (line_if.valid === 1'b1 && line_if.ready === 1'b1)
        ledger.take_beat(line_if.func, line_if.start_x, line_if.start_y, line_if.end_x,
                         line_if.end_y);
    end
  end

  // pixel receiver: random stall after each beat while recv_idle is set, plus the long hold-off on request
  initial begin
    int stall_left;
    stall_left   = 0;
    pix_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pix_taken) begin
        pix_taken = 1'b0;
        if (recv_idle) stall_left = $urandom_range(0, 13);
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left > 0) begin
        pix_if.ready <= 1'b0;
        stall_left--;
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  // send one beat, entered and left at a falling edge
  task automatic put_beat(input logic func, input int sx, input int sy, input int ex,
                          input int ey);
    int gap;
    gap = send_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      line_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    line_if.valid   <= 1'b1;
    line_if.func    <= func;
    line_if.start_x <= sx[COORD_BITS-1:0];
    line_if.start_y <= sy[COORD_BITS-1:0];
    line_if.end_x   <= ex[COORD_BITS-1:0];
    line_if.end_y   <= ey[COORD_BITS-1:0];
    do @(posedge clk); while (line_if.ready !== 1'b1);
    beats_sent++;
    @(negedge clk);
  endtask

  // step tick with junk in the unused coordinate fields
  task automatic tick();
    put_beat(FUNC_STEP, $urandom, $urandom, $urandom, $urandom);
  endtask

  // load a line and send its length plus extra ticks (negative extra cuts it short)
  task automatic run_line(input int sx, input int sy, input int ex, input int ey,
                          input int extra);
    int adx;
    int ady;
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    put_beat(FUNC_LOAD, sx, sy, ex, ey);
    repeat (((adx > ady) ? adx : ady) + extra) tick();
  endtask

  task automatic wait_for_pixels();
    int n;
    n = 0;
    while (ledger.pending() != 0 && n < 5000) begin
      @(negedge clk);
      n++;
    end
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0:       return CMIN;
      1:       return CMAX;
      default: return int'($urandom_range(0, CMAX - CMIN)) + CMIN;
    endcase
  endfunction

  // keep the end point in range by mirroring the offset
  function automatic int end_from(input int s, input int d);
    int e;
    e = s + d;
    if (e > CMAX || e < CMIN) e = s - d;
    return e;
  endfunction

  function automatic int coin_sign();
    return ($urandom_range(0, 1) == 1) ? 1 : -1;
  endfunction

  initial begin
    int  sx, sy, dx, dy, d, extra;
    bit  held, drained;
    ledger          = new();
    rst_n           = 1'b0;
    line_if.valid   = 1'b0;
    line_if.func    = FUNC_LOAD;
    line_if.start_x = '0;
    line_if.start_y = '0;
    line_if.end_x   = '0;
    line_if.end_y   = '0;
    send_idle       = 1'b0;
    recv_idle       = 1'b1;
    pix_taken       = 1'b0;
    hold_req        = 0;
    beats_sent      = 0;
    held            = 1'b0;
    drained         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero-length line, tick with nothing active
    put_beat(FUNC_LOAD, CMIN, CMAX, CMIN, CMAX);
    tick();
    // full-range diagonal, cut short by the next load
    run_line(CMIN, CMIN, CMAX, CMAX, -4094);
    // one short line per octant, each with an end point on the field extremes
    run_line(2045, CMIN, CMAX, -2047, 0);
    run_line(CMIN, 2045, -2047, CMAX, 0);
    run_line(CMAX, CMIN, 2046, -2046, 0);
    run_line(-2046, 2046, CMIN, CMAX, 0);
    run_line(CMAX, CMAX, 2045, 2046, 0);
    run_line(-2047, -2046, CMIN, CMIN, 0);
    run_line(2046, CMAX, CMAX, 2045, 0);
    run_line(CMIN, 1, -2046, 0, 0);

    // random lines, mostly complete, some broken or noise
    while (beats_sent < 950) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);

      // long receiver hold-off while ticks keep coming
      if (!held && beats_sent >= 300) begin
        held      = 1'b1;
        send_idle = 1'b0;
        @(posedge clk);
        hold_req = HOLD_LEN;
        @(negedge clk);
        sx = pick_coord();
        sy = pick_coord();
        run_line(sx, sy, end_from(sx, 48 * coin_sign()),
                 end_from(sy, $urandom_range(0, 48) * coin_sign()), 0);
      end
      // sender pause until every pixel is back
      if (!drained && beats_sent >= 600) begin
        drained = 1'b1;
        wait_for_pixels();
      end

      sx = pick_coord();
      sy = pick_coord();
      case ($urandom_range(0, 15))
        0: tick();
        1: run_line(sx, sy, sx, sy, 1);
        2: begin
          put_beat(FUNC_LOAD, sx, sy, pick_coord(), pick_coord());
          repeat ($urandom_range(3, 10)) tick();
        end
        3: begin
          dx = int'($urandom_range(0, 24)) - 12;
          dy = int'($urandom_range(0, 24)) - 12;
          run_line(sx, sy, end_from(sx, dx), end_from(sy, dy), -int'($urandom_range(1, 3)));
        end
        4: begin
          // axis and diagonal lines sit on octant borders
          d = $urandom_range(1, 12);
          case ($urandom_range(0, 2))
            0:       begin dx = d * coin_sign(); dy = 0; end
            1:       begin dx = 0; dy = d * coin_sign(); end
            default: begin dx = d * coin_sign(); dy = d * coin_sign(); end
          endcase
          run_line(sx, sy, end_from(sx, dx), end_from(sy, dy), 0);
        end
        default: begin
          dx    = int'($urandom_range(0, 24)) - 12;
          dy    = int'($urandom_range(0, 24)) - 12;
          extra = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 2)) : 0;
          run_line(sx, sy, end_from(sx, dx), end_from(sy, dy), extra);
        end
      endcase
    end

    // drain and let the pipeline settle
    line_if.valid <= 1'b0;
    wait_for_pixels();
    repeat (8) @(negedge clk);
    ledger.flag_leftover();
    if (ledger.mismatches == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule

[sim.f]
src/olr_pkg.sv
src/olr_line_if.sv
src/olr_pixel_if.sv
src/olr_setup.sv
src/octant_line_rasterizer.sv
src/olr_checker.sv
tb/sv/tb_top.sv
